FILE: rtl/core/wsp_pkg.sv
package wsp_pkg;

    // field and register widths
    localparam int SPEED_W   = 14;
    localparam int CIRC_W    = 12;
    localparam int TMO_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // default width of the elapsed-time counter
    localparam int ELAPSED_BITS_DEF = 16;

    // numerator 36 * circumference fits in 18 bits, so 18 quotient bits
    localparam int NUM_W     = CIRC_W + 6;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    // register reset values
    localparam logic              USE_FRONT_RST  = 1'b1;
    localparam logic [CIRC_W-1:0] FRONT_CIRC_RST = 12'd1626;
    localparam logic [CIRC_W-1:0] REAR_CIRC_RST  = 12'd1785;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST    = 10'd250;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_FRONT  = 2'd0,
        CFG_FRONT_CIRC = 2'd1,
        CFG_REAR_CIRC  = 2'd2,
        CFG_TIMEOUT    = 2'd3
    } cfg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic tick;      // item accepted this cycle
        logic div_step;  // one restoring division step
        logic div_last;  // final step, write the speed
        logic out_load;  // load the result register
    } wsp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;  // current item is an edge while armed
    } wsp_sts_t;

endpackage

FILE: rtl/core/wsp_ctrl.sv
module wsp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  wsp_pkg::wsp_sts_t sts,
    output wsp_pkg::wsp_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t                          state_reg, state_next;
    logic [wsp_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            accept;
    logic                            last_step;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign last_step = (cnt_reg == wsp_pkg::DIV_CNT_W'(wsp_pkg::NUM_W - 1));

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.tick = 1'b1;
                    cnt_next = '0;
                    if (sts.need_div) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cmd.div_last = last_step;
                cnt_next     = cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

FILE: rtl/core/wsp_dp.sv
module wsp_dp #(
    parameter int ELAPSED_BITS = wsp_pkg::ELAPSED_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wsp_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          hall_edge,
    input  wsp_pkg::wsp_cmd_t             cmd,
    output wsp_pkg::wsp_sts_t             sts,
    output logic [wsp_pkg::SPEED_W-1:0]   speed_kph,
    output logic                          speed_updated
);

    localparam int DEN_W = ELAPSED_BITS + 4;

    // configuration
    logic                          use_front_reg;
    logic [wsp_pkg::CIRC_W-1:0]    front_circ_reg;
    logic [wsp_pkg::CIRC_W-1:0]    rear_circ_reg;
    logic [wsp_pkg::TMO_W-1:0]     timeout_reg;

    // tick state
    logic [ELAPSED_BITS-1:0]       since_reg, since_next;
    logic [wsp_pkg::TMO_W-1:0]     window_reg, window_next;
    logic                          armed_reg, armed_next;
    logic [wsp_pkg::SPEED_W-1:0]   speed_reg, speed_next;
    logic                          updated_reg, updated_next;

    // divider
    logic [wsp_pkg::NUM_W-1:0]     q_reg, q_next;
    logic [DEN_W-1:0]              rem_reg, rem_next;
    logic [DEN_W-1:0]              den_reg, den_next;

    // result register
    logic [wsp_pkg::SPEED_W-1:0]   out_speed_reg;
    logic                          out_upd_reg;

    logic [ELAPSED_BITS-1:0]       since_inc;
    logic [wsp_pkg::TMO_W-1:0]     window_inc;
    logic [wsp_pkg::TMO_W-1:0]     limit;
    logic [wsp_pkg::CIRC_W-1:0]    circ;
    logic [wsp_pkg::NUM_W-1:0]     num;
    logic [DEN_W-1:0]              den;
    logic [DEN_W:0]                rem_sh;
    logic [DEN_W:0]                rem_diff;
    logic                          ge;
    logic [wsp_pkg::NUM_W-1:0]     q_step;

    assign sts.need_div  = hall_edge && armed_reg;
    assign speed_kph     = out_speed_reg;
    assign speed_updated = out_upd_reg;

    // saturating elapsed count, timeout window count and its limit (at least 1)
    assign since_inc  = (since_reg == '1) ? since_reg : since_reg + 1'b1;
    assign window_inc = window_reg + 1'b1;
    assign limit      = (timeout_reg == '0) ? wsp_pkg::TMO_W'(1) : timeout_reg;

    // 36 * circ and 10 * elapsed by shift and add
    assign circ = use_front_reg ? front_circ_reg : rear_circ_reg;
    assign num  = {1'b0, circ, 5'b00000} + {4'b0000, circ, 2'b00};
    assign den  = {1'b0, since_inc, 3'b000} + {3'b000, since_inc, 1'b0};

    // one restoring division step
    assign rem_sh   = {rem_reg, q_reg[wsp_pkg::NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign ge       = (rem_sh >= {1'b0, den_reg});
    assign q_step   = {q_reg[wsp_pkg::NUM_W-2:0], ge};

    always_comb begin
        since_next   = since_reg;
        window_next  = window_reg;
        armed_next   = armed_reg;
        speed_next   = speed_reg;
        updated_next = updated_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        if (cmd.tick) begin
            updated_next = 1'b0;
            if (hall_edge) begin
                if (armed_reg) begin
                    updated_next = 1'b1;
                    q_next       = num;
                    rem_next     = '0;
                    den_next     = den;
                end
                armed_next  = 1'b1;
                since_next  = '0;
                window_next = '0;
            end else begin
                since_next  = since_inc;
                window_next = window_inc;
                if (window_inc >= limit) begin
                    speed_next   = '0;
                    updated_next = 1'b1;
                    window_next  = '0;
                end
            end
        end
        if (cmd.div_step) begin
            q_next   = q_step;
            rem_next = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            if (cmd.div_last) begin
                if (q_step > wsp_pkg::NUM_W'(wsp_pkg::SPEED_MAX)) begin
                    speed_next = wsp_pkg::SPEED_MAX;
                end else begin
                    speed_next = q_step[wsp_pkg::SPEED_W-1:0];
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_front_reg  <= wsp_pkg::USE_FRONT_RST;
            front_circ_reg <= wsp_pkg::FRONT_CIRC_RST;
            rear_circ_reg  <= wsp_pkg::REAR_CIRC_RST;
            timeout_reg    <= wsp_pkg::TIMEOUT_RST;
        end else if (cfg_we) begin
            case (wsp_pkg::cfg_idx_t'(cfg_index))
                wsp_pkg::CFG_USE_FRONT:  use_front_reg  <= cfg_data[0];
                wsp_pkg::CFG_FRONT_CIRC: front_circ_reg <= cfg_data[wsp_pkg::CIRC_W-1:0];
                wsp_pkg::CFG_REAR_CIRC:  rear_circ_reg  <= cfg_data[wsp_pkg::CIRC_W-1:0];
                wsp_pkg::CFG_TIMEOUT:    timeout_reg    <= cfg_data[wsp_pkg::TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // measurement state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_reg   <= '0;
            window_reg  <= '0;
            armed_reg   <= 1'b0;
            speed_reg   <= '0;
            updated_reg <= 1'b0;
        end else begin
            since_reg   <= since_next;
            window_reg  <= window_next;
            armed_reg   <= armed_next;
            speed_reg   <= speed_next;
            updated_reg <= updated_next;
        end
    end

    // divider and result payload
    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        if (cmd.out_load) begin
            out_speed_reg <= speed_reg;
            out_upd_reg   <= updated_reg;
        end
    end

endmodule

FILE: rtl/core/wheel_speed_from_pulse_period_top.sv
// channel  | direction | fields (lowest bit up)
// s_       | in        | tdata: hall_edge[0], zero [7:1]
// m_       | out       | tdata: speed_kph[13:0], speed_updated[14], zero [15]
// cfg_     | in        | cfg_index selects the register, cfg_data its value
//
// a tick with no speed calculation goes idle to hold; an edge while armed
// divides first: an 18-step restoring divider forms 36*circ / (10*elapsed)
// reset is synchronous, active low; configuration returns to its defaults
// the result register holds one item; the next tick is accepted while it waits
// a stalled result blocks the load of the following one and further input
module wheel_speed_from_pulse_period_top #(
    parameter int ELAPSED_BITS = wsp_pkg::ELAPSED_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // hall_edge
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // speed_kph, speed_updated
    output logic [15:0]                   m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wsp_pkg::CFG_DAT_W-1:0] cfg_data
);

    wsp_pkg::wsp_cmd_t             cmd;
    wsp_pkg::wsp_sts_t             sts;
    logic [wsp_pkg::SPEED_W-1:0]   speed_kph;
    logic                          speed_updated;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {1'b0, speed_updated, speed_kph};

    wsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wsp_dp #(
        .ELAPSED_BITS (ELAPSED_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .hall_edge     (s_tdata[0]),
        .cmd           (cmd),
        .sts           (sts),
        .speed_kph     (speed_kph),
        .speed_updated (speed_updated)
    );

endmodule
